/* hw/rtl/tvc_pkg.sv */
// Shared types and constants for the teleop velocity commander.
package tvc_pkg;

   // Drive mode codes.
   localparam logic [1:0] MODE_DIFF = 2'd0;
   localparam logic [1:0] MODE_OMNI = 2'd1;
   localparam logic [1:0] MODE_ACK  = 2'd2;

   // Output target codes.
   localparam logic [1:0] TGT_NORMAL = 2'd0;
   localparam logic [1:0] TGT_UNSAFE = 2'd1;
   localparam logic [1:0] TGT_BOTH   = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] CSR_MAX_LIN  = 3'd0;
   localparam logic [2:0] CSR_MAX_ANG  = 3'd1;
   localparam logic [2:0] CSR_WHEEL    = 3'd2;
   localparam logic [2:0] CSR_WD_EN    = 3'd3;
   localparam logic [2:0] CSR_WD_MS    = 3'd4;

   localparam logic [3:0] LEVEL_MIN = 4'd1;
   localparam logic [3:0] LEVEL_MAX = 4'd10;

   localparam longint unsigned ONE_Q30     = 64'd1073741824;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef struct packed {
      logic [13:0] max_lin;
      logic [13:0] max_ang;
      logic [13:0] wheel_mm;
      logic        wd_en;
      logic [15:0] wd_ms;
   } cfg_type;

   // One classified word handed from the front to the back.
   typedef struct packed {
      logic               stop;
      logic [1:0]         target;
      logic [3:0]         level;
      logic [1:0]         mode;
      logic               tripped;
      logic signed [15:0] fwd;
      logic signed [15:0] side;
      logic signed [15:0] turn;
   } cmd_type;

   typedef struct packed {
      logic signed [15:0] fwd;
      logic signed [15:0] side;
      logic signed [15:0] turn;
      logic [1:0]         target;
      logic [3:0]         level;
      logic [1:0]         mode;
      logic               tripped;
   } rsp_type;

   function automatic logic [15:0] mag16(input logic signed [15:0] v);
      return v[15] ? (~v + 16'd1) : v;
   endfunction

endpackage

/* hw/rtl/tvc_front.sv */
// Front end: accepts gamepad words, runs deadman and watchdog, updates level and mode.
module tvc_front (
   input  logic              clock,
   input  logic              reset,
   input  tvc_pkg::cfg_type  cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [103:0]      in_data,
   input  logic              fifo_full,
   output logic              push,
   output tvc_pkg::cmd_type  push_cmd
);

   logic [3:0]  level_ff, level_in;
   logic [1:0]  mode_ff, mode_in;
   logic [15:0] last_accel_ff, last_accel_in;
   logic [31:0] last_time_ff, last_time_in;
   logic        wd_ff, wd_in;

   logic               accept, go;
   logic               held, let_go, unsafe, faster, slower, mode_btn;
   logic [15:0]        accel;
   logic [31:0]        now, elapsed;

   assign in_ready = !fifo_full;
   assign accept   = in_valid && !fifo_full;
   assign held     = in_data[0];
   assign let_go   = in_data[1];
   assign unsafe   = in_data[2];
   assign faster   = in_data[3];
   assign slower   = in_data[4];
   assign mode_btn = in_data[5];
   assign accel    = in_data[69:54];
   assign now      = in_data[101:70];
   assign elapsed  = now - last_time_ff;

   always_comb begin
      level_in      = level_ff;
      mode_in       = mode_ff;
      last_accel_in = last_accel_ff;
      last_time_in  = last_time_ff;
      wd_in         = wd_ff;
      go            = 1'b0;
      push          = 1'b0;
      push_cmd.stop    = 1'b1;
      push_cmd.target  = tvc_pkg::TGT_BOTH;
      push_cmd.level   = level_ff;
      push_cmd.mode    = mode_ff;
      push_cmd.tripped = wd_ff;
      push_cmd.fwd     = in_data[21:6];
      push_cmd.side    = in_data[37:22];
      push_cmd.turn    = in_data[53:38];
      if (accept) begin
         if (let_go) begin
            push = 1'b1;
         end else if (held) begin
            go = 1'b1;
            if (cfg.wd_en) begin
               if (accel != last_accel_ff) begin
                  last_accel_in = accel;
                  last_time_in  = now;
                  wd_in         = 1'b0;
               end else if (wd_ff) begin
                  go = 1'b0;
               end else if (elapsed >= {16'd0, cfg.wd_ms}) begin
                  // Stale sensor: one stop word, then silence until it moves.
                  wd_in            = 1'b1;
                  go               = 1'b0;
                  push             = 1'b1;
                  push_cmd.tripped = 1'b1;
               end
            end
            if (go) begin
               if (slower) begin
                  if (level_ff > tvc_pkg::LEVEL_MIN) level_in = level_ff - 4'd1;
               end else if (faster) begin
                  if (level_ff < tvc_pkg::LEVEL_MAX) level_in = level_ff + 4'd1;
               end
               if (mode_btn) begin
                  case (mode_ff)
                     tvc_pkg::MODE_DIFF: mode_in = tvc_pkg::MODE_OMNI;
                     tvc_pkg::MODE_OMNI: mode_in = (cfg.wheel_mm != 14'd0) ?
                                                   tvc_pkg::MODE_ACK : tvc_pkg::MODE_DIFF;
                     default:            mode_in = tvc_pkg::MODE_DIFF;
                  endcase
               end
               push             = 1'b1;
               push_cmd.stop    = 1'b0;
               push_cmd.target  = unsafe ? tvc_pkg::TGT_UNSAFE : tvc_pkg::TGT_NORMAL;
               push_cmd.level   = level_in;
               push_cmd.mode    = mode_in;
               push_cmd.tripped = wd_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff      <= tvc_pkg::LEVEL_MIN;
         mode_ff       <= tvc_pkg::MODE_DIFF;
         last_accel_ff <= 16'd0;
         last_time_ff  <= 32'd0;
         wd_ff         <= 1'b0;
      end else begin
         level_ff      <= level_in;
         mode_ff       <= mode_in;
         last_accel_ff <= last_accel_in;
         last_time_ff  <= last_time_in;
         wd_ff         <= wd_in;
      end
   end

endmodule

/* hw/rtl/tvc_fifo.sv */
// Two-entry queue of classified words between the front and the back.
module tvc_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tvc_pkg::cmd_type push_cmd,
   input  logic             pop,
   output tvc_pkg::cmd_type head,
   output logic             full,
   output logic             empty
);

   tvc_pkg::cmd_type mem_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         if (push && !pop)      count_ff <= count_ff + 2'd1;
         else if (pop && !push) count_ff <= count_ff - 2'd1;
      end
   end

endmodule

/* hw/rtl/tvc_back.sv */
// Back end: scales stick axes into saturated velocity commands and holds the result word.
module tvc_back #(
   parameter int TRIG_TABLE_ENTRIES = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  tvc_pkg::cfg_type cfg,
   input  tvc_pkg::cmd_type head,
   input  logic             empty,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tvc_pkg::rsp_type rsp
);

   localparam int IDX_W = $clog2(TRIG_TABLE_ENTRIES + 1);

   typedef enum logic [3:0] {
      B_IDLE, B_LIN, B_PROD, B_REDUCE, B_ACK, B_ACK2, B_ACK3,
      B_SCALE, B_DIVCHK, B_DIV, B_OUT
   } state_type;

   // Quarter sine in Q15, built by a Q30 Horner series.
   function automatic logic [15:0] sin_q15(input longint unsigned k);
      longint unsigned x, x2, t, r;
      x  = (k * tvc_pkg::HALF_PI_Q30 + 64'(TRIG_TABLE_ENTRIES / 2)) / TRIG_TABLE_ENTRIES;
      x2 = (x * x) >> 30;
      t  = tvc_pkg::ONE_Q30;
      t  = tvc_pkg::ONE_Q30 - ((x2 * t) >> 30) / 64'd272;
      t  = tvc_pkg::ONE_Q30 - ((x2 * t) >> 30) / 64'd210;
      t  = tvc_pkg::ONE_Q30 - ((x2 * t) >> 30) / 64'd156;
      t  = tvc_pkg::ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
      t  = tvc_pkg::ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
      t  = tvc_pkg::ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
      t  = tvc_pkg::ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
      t  = tvc_pkg::ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
      r  = (((x * t) >> 30) + 64'd16384) >> 15;
      return r[15:0];
   endfunction

   // Quotient by ten, rounded down, capped at 32768; y below the cap stays under 2^19.
   function automatic logic [15:0] div10_sat(input logic [19:0] y);
      logic [39:0] p;
      p = 40'(y) * 40'd419431;
      if (y >= 20'd327680) return 16'h8000;
      return p[37:22];
   endfunction

   function automatic logic [15:0] apply_sign(input logic [15:0] q, input logic neg);
      if (neg) return ~q + 16'd1;
      return q[15] ? 16'h7FFF : q;
   endfunction

   logic [15:0] trig_rom [TRIG_TABLE_ENTRIES + 1];
   for (genvar k = 0; k <= TRIG_TABLE_ENTRIES; k++) begin : g_rom
      assign trig_rom[k] = sin_q15(64'(k));
   end

   state_type        state_ff;
   tvc_pkg::cmd_type cmd_ff;
   logic [17:0]      lin_ff, ang_ff, dden_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [33:0]      pf_ff, ps_ff, pt_ff;
   logic [15:0]      sn_ff, cs_ff;
   logic [49:0]      pa_ff, pb_ff;
   logic [59:0]      pc_ff;
   logic [19:0]      yf_ff, ys_ff, yt_ff;
   logic [28:0]      ydiv_ff, rem_ff;
   logic [15:0]      qf_ff, qs_ff, qt_ff;
   logic [3:0]       cnt_ff;
   logic             rsp_valid_ff;
   tvc_pkg::rsp_type rsp_ff;

   logic [15:0] mf, ms, mt;
   logic [31:0] idx_full;
   logic [33:0] div_step;
   logic        turn_neg;

   assign mf       = tvc_pkg::mag16(cmd_ff.fwd);
   assign ms       = tvc_pkg::mag16(cmd_ff.side);
   assign mt       = tvc_pkg::mag16(cmd_ff.turn);
   assign idx_full = ({16'd0, mt} * 32'(TRIG_TABLE_ENTRIES) + 32'd16384) >> 15;
   assign div_step = 34'(dden_ff) << cnt_ff;
   assign turn_neg = (cmd_ff.mode == tvc_pkg::MODE_ACK) ? (cmd_ff.fwd[15] ^ cmd_ff.turn[15])
                                                        : cmd_ff.turn[15];
   assign pop       = (state_ff == B_IDLE) && !empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // B_OUT handles the valid flag itself when it loads a new word.
         if (rsp_valid_ff && rsp_ready && state_ff != B_OUT) rsp_valid_ff <= 1'b0;
         case (state_ff)
            B_IDLE: begin
               if (!empty) begin
                  cmd_ff <= head;
                  qf_ff  <= 16'd0;
                  qs_ff  <= 16'd0;
                  qt_ff  <= 16'd0;
                  state_ff <= head.stop ? B_OUT : B_LIN;
               end
            end
            B_LIN: begin
               lin_ff   <= 18'(cmd_ff.level) * 18'(cfg.max_lin);
               ang_ff   <= 18'(cmd_ff.level) * 18'(cfg.max_ang);
               idx_ff   <= idx_full[IDX_W-1:0];
               state_ff <= B_PROD;
            end
            B_PROD: begin
               pf_ff <= 34'(lin_ff) * 34'(mf);
               ps_ff <= 34'(lin_ff) * 34'(ms);
               pt_ff <= 34'(ang_ff) * 34'(mt);
               sn_ff <= trig_rom[idx_ff];
               cs_ff <= trig_rom[IDX_W'(TRIG_TABLE_ENTRIES) - idx_ff];
               state_ff <= (cmd_ff.mode == tvc_pkg::MODE_ACK) ? B_ACK : B_REDUCE;
            end
            B_REDUCE: begin
               yf_ff    <= 20'(pf_ff[33:15]) + 20'd5;
               ys_ff    <= 20'(ps_ff[33:15]) + 20'd5;
               yt_ff    <= 20'(pt_ff[33:15]) + 20'd5;
               state_ff <= B_SCALE;
            end
            B_ACK: begin
               pa_ff    <= 50'(pf_ff) * 50'(cs_ff);
               pb_ff    <= 50'(pf_ff) * 50'(sn_ff);
               state_ff <= B_ACK2;
            end
            B_ACK2: begin
               yf_ff    <= pa_ff[49:30] + 20'd5;
               ys_ff    <= 20'd0;
               yt_ff    <= 20'd0;
               pc_ff    <= 60'(pb_ff) * 60'd1000;
               state_ff <= B_ACK3;
            end
            B_ACK3: begin
               ydiv_ff  <= pc_ff[58:30] + 29'(cfg.wheel_mm) * 29'd5;
               dden_ff  <= 18'(cfg.wheel_mm) * 18'd10;
               state_ff <= B_SCALE;
            end
            B_SCALE: begin
               qf_ff    <= div10_sat(yf_ff);
               qs_ff    <= div10_sat(ys_ff);
               qt_ff    <= div10_sat(yt_ff);
               state_ff <= (cmd_ff.mode == tvc_pkg::MODE_ACK) ? B_DIVCHK : B_OUT;
            end
            B_DIVCHK: begin
               rem_ff <= ydiv_ff;
               cnt_ff <= 4'd14;
               if (cfg.wheel_mm == 14'd0) begin
                  qt_ff    <= 16'd0;
                  state_ff <= B_OUT;
               end else if (34'(ydiv_ff) >= (34'(dden_ff) << 15)) begin
                  qt_ff    <= 16'h8000;
                  state_ff <= B_OUT;
               end else begin
                  qt_ff    <= 16'd0;
                  state_ff <= B_DIV;
               end
            end
            B_DIV: begin
               if (34'(rem_ff) >= div_step) begin
                  rem_ff        <= rem_ff - div_step[28:0];
                  qt_ff[cnt_ff] <= 1'b1;
               end
               cnt_ff <= cnt_ff - 4'd1;
               if (cnt_ff == 4'd0) state_ff <= B_OUT;
            end
            B_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff.fwd     <= apply_sign(qf_ff, cmd_ff.fwd[15]);
                  rsp_ff.side    <= (cmd_ff.mode == tvc_pkg::MODE_OMNI) ?
                                    apply_sign(qs_ff, cmd_ff.side[15]) : 16'd0;
                  rsp_ff.turn    <= apply_sign(qt_ff, turn_neg);
                  rsp_ff.target  <= cmd_ff.target;
                  rsp_ff.level   <= cmd_ff.level;
                  rsp_ff.mode    <= cmd_ff.mode;
                  rsp_ff.tripped <= cmd_ff.tripped;
                  rsp_valid_ff   <= 1'b1;
                  state_ff       <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule

/* hw/rtl/teleop_velocity_commander_core.sv */
// Top level of the gamepad teleop velocity commander with deadman and watchdog.
// Each accepted req word is one gamepad sample and gives at most one rsp word. The front
// end takes a sample in its accept cycle, applies the deadman and accelerometer watchdog,
// updates speed level and drive mode, and places a word in a two-entry queue; req_tready
// drops only while that queue is full. The back end turns each queued word into
// velocities: a stop word goes straight to the output register, a differential or omni
// word through a chain of registered multiplies and a reciprocal divide by ten. An
// Ackermann word also passes the bit-serial divider (one quotient bit per cycle over 15
// bits) that divides the turn rate by the wheel base. The finished word waits in an
// output register, so the back end goes on with the next queued word while rsp is
// stalled. Configuration should be written only while no word is in flight.
module teleop_velocity_commander_core #(
   parameter int TRIG_TABLE_ENTRIES = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // deadman_held, deadman_let_go, unsafe_held, faster_let_go, slower_let_go,
   // mode_let_go, stick_forward, stick_sideways, stick_turn, accel_sample, time_ms
   input  logic [103:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // forward_cmd, sideways_cmd, turn_cmd, level_now, mode_now, tripped
   output logic [55:0]  rsp_tdata,
   // target
   output logic [1:0]   rsp_tuser,
   input  logic         csr_wen,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   tvc_pkg::cfg_type cfg_ff;
   tvc_pkg::cmd_type push_cmd, head;
   tvc_pkg::rsp_type rsp;
   logic             push, pop, fifo_full, fifo_empty;

   // Configuration registers; writes beyond the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_lin    <= 14'd1500;
         cfg_ff.max_ang    <= 14'd1500;
         cfg_ff.wheel_mm   <= 14'd0;
         cfg_ff.wd_en      <= 1'b1;
         cfg_ff.wd_ms      <= 16'd500;
      end else if (csr_wen) begin
         case (csr_index)
            tvc_pkg::CSR_MAX_LIN: cfg_ff.max_lin    <= csr_wdata[13:0];
            tvc_pkg::CSR_MAX_ANG: cfg_ff.max_ang    <= csr_wdata[13:0];
            tvc_pkg::CSR_WHEEL:   cfg_ff.wheel_mm   <= csr_wdata[13:0];
            tvc_pkg::CSR_WD_EN:   cfg_ff.wd_en      <= csr_wdata[0];
            tvc_pkg::CSR_WD_MS:   cfg_ff.wd_ms      <= csr_wdata;
            default: ;
         endcase
      end
   end

   tvc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .fifo_full (fifo_full),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   tvc_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .full     (fifo_full),
      .empty    (fifo_empty)
   );

   tvc_back #(
      .TRIG_TABLE_ENTRIES (TRIG_TABLE_ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (head),
      .empty     (fifo_empty),
      .pop       (pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {1'b0, rsp.tripped, rsp.mode, rsp.level, rsp.turn, rsp.side, rsp.fwd};
   assign rsp_tuser = rsp.target;

endmodule

/* dv/tb_teleop_velocity_commander_core.sv */
// Self-checking testbench for the teleop velocity commander core.
`timescale 1ns / 100ps

module tb_teleop_velocity_commander_core;

   localparam int  TRIG_N      = 256;
   localparam int  CYCLE_LIMIT = 2000000;
   // Longest internal path (an Ackermann word) plus queue depth, with margin.
   localparam int  DRAIN_CYCLES = 80;
   // Length of the long receiver hold-off.
   localparam int  HOLD_CYCLES = 300;

   // One gamepad sample as the block sees it.
   typedef struct {
      bit                 held;
      bit                 let_go;
      bit                 unsafe;
      bit                 faster;
      bit                 slower;
      bit                 mode_btn;
      logic signed [15:0] fwd;
      logic signed [15:0] side;
      logic signed [15:0] turn;
      logic signed [15:0] accel;
      logic [31:0]        tms;
   } pad_sample_type;

   // A directed row: the sample and, where it is obvious, the result it must give.
   typedef struct {
      pad_sample_type   smp;
      bit               typed;
      tvc_pkg::rsp_type want;
   } pad_row_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [103:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [55:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_wen;
   logic [2:0]   csr_index;
   logic [15:0]  csr_wdata;

   teleop_velocity_commander_core #(.TRIG_TABLE_ENTRIES(TRIG_N)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Predictor copy of the configuration and of the block's state.
   logic [13:0] cfg_lin, cfg_ang, cfg_wheel;
   logic        cfg_wd_en;
   logic [15:0] cfg_wd_ms;
   logic [3:0]  st_level;
   logic [1:0]  st_mode;
   logic [15:0] st_last_accel;
   logic [31:0] st_last_change;
   logic        st_tripped;
   int          sine_q15 [0:TRIG_N];

   tvc_pkg::rsp_type pending_cmds [$];
   int          fail_count;
   int          cycle_count;
   int          items_sent;
   int          words_seen;
   int          stops_seen;
   int          ack_words;
   bit          hold_off;
   bit          start_hold;
   bit          no_idle;

   // The clock toggles every half period of 10 ns.
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Quarter-wave sine table in Q15, built from a Horner series in Q30.
   function automatic void build_sine_table();
      longint unsigned x, x2, t, d;
      for (int k = 0; k <= TRIG_N; k++) begin
         x  = (longint'(k) * tvc_pkg::HALF_PI_Q30 + TRIG_N / 2) / TRIG_N;
         x2 = (x * x) >> 30;
         t  = tvc_pkg::ONE_Q30;
         for (int n = 8; n >= 1; n--) begin
            d = (2 * n) * (2 * n + 1);
            t = tvc_pkg::ONE_Q30 - ((x2 * t) >> 30) / d;
         end
         sine_q15[k] = int'((((x * t) >> 30) + (64'd1 << 14)) >> 15);
      end
   endfunction

   // Divide with rounding half away from zero, then clamp to 16 bits signed.
   function automatic logic [15:0] round_sat16(input longint num, input longint unsigned den);
      longint unsigned mag, q;
      longint          v;
      mag = (num < 0) ? longint'(-num) : longint'(num);
      q   = (mag + den / 2) / den;
      if (q > 32768) q = 32768;
      v = (num < 0) ? -longint'(q) : longint'(q);
      if (v > 32767) v = 32767;
      return v[15:0];
   endfunction

   function automatic tvc_pkg::rsp_type stop_word();
      tvc_pkg::rsp_type r;
      r.fwd     = '0;
      r.side    = '0;
      r.turn    = '0;
      r.target  = tvc_pkg::TGT_BOTH;
      r.level   = st_level;
      r.mode    = st_mode;
      r.tripped = st_tripped;
      return r;
   endfunction

   // Works out the velocity word for one sample and advances the predicted state.
   // Returns 0 where the sample gives no word.
   function automatic bit predict_velocity(input pad_sample_type s,
                                           output tvc_pkg::rsp_type r);
      longint lin, fmag, idx, sn, cs;
      r = stop_word();
      if (s.let_go) return 1'b1;
      if (!s.held) return 1'b0;
      if (cfg_wd_en) begin
         if (s.accel != st_last_accel) begin
            st_last_accel  = s.accel;
            st_last_change = s.tms;
            st_tripped     = 1'b0;
         end else begin
            if (st_tripped) return 1'b0;
            if (32'(s.tms - st_last_change) >= {16'd0, cfg_wd_ms}) begin
               st_tripped = 1'b1;
               r = stop_word();
               return 1'b1;
            end
         end
      end
      // Slower wins when both speed buttons come up in the same sample.
      if (s.slower) begin
         if (st_level > tvc_pkg::LEVEL_MIN) st_level--;
      end else if (s.faster) begin
         if (st_level < tvc_pkg::LEVEL_MAX) st_level++;
      end
      if (s.mode_btn) begin
         case (st_mode)
            tvc_pkg::MODE_DIFF: st_mode = tvc_pkg::MODE_OMNI;
            tvc_pkg::MODE_OMNI: st_mode = (cfg_wheel != 0) ? tvc_pkg::MODE_ACK
                                                           : tvc_pkg::MODE_DIFF;
            default:            st_mode = tvc_pkg::MODE_DIFF;
         endcase
      end
      lin = longint'(st_level) * longint'(cfg_lin);
      r.level   = st_level;
      r.mode    = st_mode;
      r.tripped = st_tripped;
      r.target  = s.unsafe ? tvc_pkg::TGT_UNSAFE : tvc_pkg::TGT_NORMAL;
      r.side    = '0;
      if (st_mode == tvc_pkg::MODE_ACK) begin
         fmag = (s.turn < 0) ? -longint'(s.turn) : longint'(s.turn);
         idx  = (fmag * TRIG_N + 16384) >>> 15;
         if (idx > TRIG_N) idx = TRIG_N;
         sn = sine_q15[idx];
         if (s.turn < 0) sn = -sn;
         cs = sine_q15[TRIG_N - idx];
         r.fwd = round_sat16(lin * longint'(s.fwd) * cs, 10 * tvc_pkg::ONE_Q30);
         // A wheel base cleared while in Ackermann mode leaves no turn rate.
         if (cfg_wheel != 0)
            r.turn = round_sat16(1000 * lin * longint'(s.fwd) * sn,
                                 10 * tvc_pkg::ONE_Q30 * longint'(cfg_wheel));
         else
            r.turn = '0;
      end else begin
         r.fwd  = round_sat16(lin * longint'(s.fwd), 327680);
         r.turn = round_sat16(longint'(st_level) * longint'(cfg_ang) * longint'(s.turn),
                              327680);
         if (st_mode == tvc_pkg::MODE_OMNI)
            r.side = round_sat16(lin * longint'(s.side), 327680);
      end
      return 1'b1;
   endfunction

   // Packs a sample into req_tdata, first field in the lowest bits.
   function automatic logic [103:0] pack_sample(input pad_sample_type s);
      return {2'b00, s.tms, s.accel, s.turn, s.side, s.fwd,
              s.mode_btn, s.slower, s.faster, s.unsafe, s.let_go, s.held};
   endfunction

   // Stick or accelerometer value with a bias toward the ends of the range and zero.
   function automatic logic signed [15:0] pick_axis();
      case ($urandom_range(0, 9))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return 16'sh0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // Register write, mirrored into the predictor; the enable then drops before the task returns.
   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wen   <= 1'b0;
      case (idx)
         tvc_pkg::CSR_MAX_LIN: cfg_lin   = val[13:0];
         tvc_pkg::CSR_MAX_ANG: cfg_ang   = val[13:0];
         tvc_pkg::CSR_WHEEL:   cfg_wheel = val[13:0];
         tvc_pkg::CSR_WD_EN:   cfg_wd_en = val[0];
         tvc_pkg::CSR_WD_MS:   cfg_wd_ms = val;
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Offers one word, waits for the handshake, and then maybe leaves a gap.
   task automatic offer_sample(input pad_sample_type s, input bit typed,
                               input tvc_pkg::rsp_type want);
      tvc_pkg::rsp_type got;
      int               gap;
      req_tvalid <= 1'b1;
      req_tdata  <= pack_sample(s);
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (predict_velocity(s, got))
         pending_cmds.insert(pending_cmds.size(), typed ? want : got);
      @(negedge clock);
      gap = 0;
      if (!no_idle) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3: gap = $urandom_range(1, 3);
            4:          gap = $urandom_range(20, 90);
            default:    gap = 0;
         endcase
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Waits until every expected word has come back and the core has gone quiet.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_cmds.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Long receiver hold-off, timed in this process while the sender keeps offering.
   initial begin
      hold_off = 1'b0;
      wait (start_hold);
      @(negedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      hold_off <= 1'b0;
   end

   // The receiver stalls at random, except while the long hold-off runs.
   int stall_left;
   always @(negedge clock) begin
      if (reset || hold_off) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                    : $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compares every accepted result word with the oldest expectation.
   always @(posedge clock) begin
      tvc_pkg::rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_seen++;
         if (pending_cmds.size() == 0) begin
            $error("result word with nothing expected: data %h user %h", rsp_tdata, rsp_tuser);
            fail_count++;
         end else begin
            want = pending_cmds.pop_front();
            if (want.target == tvc_pkg::TGT_BOTH) stops_seen++;
            if (want.mode == tvc_pkg::MODE_ACK && want.target != tvc_pkg::TGT_BOTH)
               ack_words++;
            if (rsp_tdata[15:0] !== want.fwd) begin
               $error("forward_cmd: expected %0d, got %0d", want.fwd,
                      $signed(rsp_tdata[15:0]));
               fail_count++;
            end
            if (rsp_tdata[31:16] !== want.side) begin
               $error("sideways_cmd: expected %0d, got %0d", want.side,
                      $signed(rsp_tdata[31:16]));
               fail_count++;
            end
            if (rsp_tdata[47:32] !== want.turn) begin
               $error("turn_cmd: expected %0d, got %0d", want.turn,
                      $signed(rsp_tdata[47:32]));
               fail_count++;
            end
            if (rsp_tdata[51:48] !== want.level) begin
               $error("level_now: expected %0d, got %0d", want.level, rsp_tdata[51:48]);
               fail_count++;
            end
            if (rsp_tdata[53:52] !== want.mode) begin
               $error("mode_now: expected %0d, got %0d", want.mode, rsp_tdata[53:52]);
               fail_count++;
            end
            if (rsp_tdata[54] !== want.tripped) begin
               $error("tripped: expected %0d, got %0d", want.tripped, rsp_tdata[54]);
               fail_count++;
            end
            if (rsp_tuser !== want.target) begin
               $error("target: expected %0d, got %0d", want.target, rsp_tuser);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Main sequence: reset, a directed table, then random phases under several
   // configurations, with one long receiver hold-off along the way.
   pad_row_type      drows [$];
   pad_sample_type   smp;
   tvc_pkg::rsp_type none_word;
   logic [31:0]      clock_ms;
   logic [15:0]      accel_now;
   int               roll;

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_wen     = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      start_hold  = 1'b0;
      no_idle     = 1'b0;
      items_sent  = 0;
      none_word   = '0;
      cfg_lin = 14'd1500; cfg_ang = 14'd1500; cfg_wheel = '0;
      cfg_wd_en = 1'b1; cfg_wd_ms = 16'd500;
      st_level = tvc_pkg::LEVEL_MIN; st_mode = tvc_pkg::MODE_DIFF; st_last_accel = '0;
      st_last_change = '0; st_tripped = 1'b0;
      build_sine_table();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (4) @(negedge clock);

      // Directed table. Rows with typed results are read straight off the spec.
      smp = '{default: '0};
      // Deadman let go right after reset: a stop to both outputs at level 1.
      smp.let_go = 1; smp.held = 1;
      drows.insert(drows.size(), '{smp, 1, '{16'sd0, 16'sd0, 16'sd0, tvc_pkg::TGT_BOTH,
                                             tvc_pkg::LEVEL_MIN, tvc_pkg::MODE_DIFF, 1'b0}});
      // Neither held nor let go: nothing comes back.
      smp = '{default: '0}; smp.fwd = 16'sh7FFF;
      drows.insert(drows.size(), '{smp, 0, none_word});
      // Full sticks, accelerometer moving.
      smp = '{default: '0}; smp.held = 1; smp.fwd = 16'sh7FFF; smp.turn = 16'sh8000;
      smp.accel = 16'sd1; smp.tms = 32'd10;
      drows.insert(drows.size(), '{smp, 0, none_word});
      // Accelerometer stale past the limit: one stop with the watchdog tripped,
      // and the faster button of that sample is ignored.
      smp.tms = 32'd600; smp.faster = 1;
      drows.insert(drows.size(), '{smp, 1, '{16'sd0, 16'sd0, 16'sd0, tvc_pkg::TGT_BOTH,
                                             tvc_pkg::LEVEL_MIN, tvc_pkg::MODE_DIFF, 1'b1}});
      // Still stale while tripped: discarded.
      smp.tms = 32'd700;
      drows.insert(drows.size(), '{smp, 0, none_word});
      // Value changes: the watchdog clears, level goes up.
      smp = '{default: '0}; smp.held = 1; smp.faster = 1; smp.fwd = 16'sh8000;
      smp.turn = 16'sh7FFF; smp.accel = 16'sh8000; smp.tms = 32'd710; smp.unsafe = 1;
      drows.insert(drows.size(), '{smp, 0, none_word});
      // Walk the level up to the top and past it.
      for (int i = 0; i < 10; i++) begin
         smp.accel = 16'(i + 2); smp.tms = 32'd720 + i; smp.unsafe = i[0];
         drows.insert(drows.size(), '{smp, 0, none_word});
      end
      // Both speed buttons: slower wins.
      smp.slower = 1; smp.accel = 16'sh7FFF;
      drows.insert(drows.size(), '{smp, 0, none_word});
      // Mode to omni, with the sideways axis at both ends.
      smp = '{default: '0}; smp.held = 1; smp.mode_btn = 1; smp.side = 16'sh8000;
      smp.fwd = 16'sh4000; smp.accel = 16'sd5; smp.tms = 32'd800;
      drows.insert(drows.size(), '{smp, 0, none_word});
      smp.mode_btn = 0; smp.side = 16'sh7FFF; smp.accel = 16'sd6;
      drows.insert(drows.size(), '{smp, 0, none_word});
      // Omni with no wheel base goes back to differential.
      smp.mode_btn = 1; smp.accel = 16'sd7;
      drows.insert(drows.size(), '{smp, 0, none_word});
      // Let go while the level is high.
      smp.let_go = 1; smp.held = 0;
      drows.insert(drows.size(), '{smp, 0, none_word});

      foreach (drows[i]) offer_sample(drows[i].smp, drows[i].typed, drows[i].want);
      wait_idle();

      clock_ms  = 32'd1000;
      accel_now = 16'd0;
      for (int ph = 0; ph < 6; ph++) begin
         // Configuration of this phase; the first and last cover the extremes.
         case (ph)
            0: begin
               write_reg(tvc_pkg::CSR_MAX_LIN, 16'd10000);
               write_reg(tvc_pkg::CSR_MAX_ANG, 16'd10000);
               write_reg(tvc_pkg::CSR_WHEEL, 16'd1); write_reg(tvc_pkg::CSR_WD_EN, 16'd1);
               write_reg(tvc_pkg::CSR_WD_MS, 16'd0);
            end
            1: begin
               write_reg(tvc_pkg::CSR_MAX_LIN, 16'd0); write_reg(tvc_pkg::CSR_MAX_ANG, 16'd0);
               write_reg(tvc_pkg::CSR_WHEEL, 16'd10000);
               write_reg(tvc_pkg::CSR_WD_EN, 16'd0);
               write_reg(tvc_pkg::CSR_WD_MS, 16'hFFFF);
            end
            5: begin
               // Clear the wheel base so any Ackermann state loses its turn rate.
               write_reg(tvc_pkg::CSR_WHEEL, 16'd0); write_reg(tvc_pkg::CSR_WD_EN, 16'd1);
               write_reg(tvc_pkg::CSR_WD_MS, 16'd40);
               clock_ms = 32'hFFFF_FF00;
            end
            default: begin
               write_reg(tvc_pkg::CSR_MAX_LIN, 16'($urandom_range(0, 10000)));
               write_reg(tvc_pkg::CSR_MAX_ANG, 16'($urandom_range(0, 10000)));
               write_reg(tvc_pkg::CSR_WHEEL, 16'($urandom_range(1, 10000)));
               write_reg(tvc_pkg::CSR_WD_EN, 16'($urandom_range(0, 1)));
               write_reg(tvc_pkg::CSR_WD_MS, 16'($urandom_range(0, 200)));
            end
         endcase
         no_idle = (ph == 3);
         if (ph == 2) start_hold = 1'b1;

         for (int n = 0; n < 82; n++) begin
            smp = '{default: '0};
            roll = $urandom_range(0, 99);
            smp.held     = (roll >= 6);
            smp.let_go   = (roll < 4);
            smp.unsafe   = $urandom_range(0, 1);
            smp.faster   = ($urandom_range(0, 3) == 0);
            smp.slower   = ($urandom_range(0, 4) == 0);
            smp.mode_btn = ($urandom_range(0, 3) == 0);
            smp.fwd      = pick_axis();
            smp.side     = pick_axis();
            smp.turn     = pick_axis();
            // Time moves on; the accelerometer mostly changes, sometimes freezes.
            clock_ms = clock_ms + (($urandom_range(0, 9) == 0) ? $urandom_range(0, 70000)
                                                               : $urandom_range(0, 30));
            if ($urandom_range(0, 9) == 0) clock_ms = $urandom;
            if ($urandom_range(0, 2) != 0) accel_now = pick_axis();
            smp.accel = accel_now;
            smp.tms   = clock_ms;
            offer_sample(smp, 0, none_word);
         end
         wait_idle();
      end

      $display("Summary: %0d samples driven, %0d words checked, %0d stop words,",
               items_sent, words_seen, stops_seen);
      $display("         %0d Ackermann words, six register settings after the table.",
               ack_words);
      if (fail_count == 0 && pending_cmds.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         if (pending_cmds.size() != 0)
            $error("%0d expected words never came back", pending_cmds.size());
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
